// File: rtl/core/tpvt_pkg.sv
package tpvt_pkg;

	// Page grid of the tracker.
	localparam int PAGE_COLUMNS = 16;
	localparam int PAGE_ROWS    = 2;
	localparam int NUM_TYPES    = 3;

	// Video memory geometry, in lines and halfwords.
	localparam int ROW_LINES        = 256;
	localparam int COL_HALFWORDS    = 64;
	localparam int SPAN8_HALFWORDS  = 128;
	localparam int SPAN16_HALFWORDS = 256;
	localparam int VRAM_WIDTH       = 1024;
	localparam int VRAM_HEIGHT      = 512;
	localparam int CLUT_UNIT_SHIFT  = 4;
	localparam int CLUT_SMALL       = 16;
	localparam int CLUT_LARGE       = 256;

	// Request actions.
	localparam logic [1:0] ACT_TEX_QUERY  = 2'd0;
	localparam logic [1:0] ACT_CLUT_QUERY = 2'd1;
	localparam logic [1:0] ACT_INVALIDATE = 2'd2;

	// Page types.
	localparam logic [1:0] TYPE_4BIT  = 2'd0;
	localparam logic [1:0] TYPE_8BIT  = 2'd1;
	localparam logic [1:0] TYPE_16BIT = 2'd2;
	localparam logic [1:0] TYPE_24BIT = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  page_type;
		logic [3:0]  page_column;
		logic        page_row;
		logic [5:0]  clut_column;
		logic [8:0]  clut_row;
		logic [9:0]  rect_left;
		logic [8:0]  rect_top;
		logic [10:0] rect_right;
		logic [9:0]  rect_bottom;
	} req_t;

endpackage

// File: rtl/core/tpvt_if.sv
interface tpvt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  page_type;
	logic [3:0]  page_column;
	logic        page_row;
	logic [5:0]  clut_column;
	logic [8:0]  clut_row;
	logic [9:0]  rect_left;
	logic [8:0]  rect_top;
	logic [10:0] rect_right;
	logic [9:0]  rect_bottom;

	modport source (
		output valid, action, page_type, page_column, page_row, clut_column, clut_row,
		       rect_left, rect_top, rect_right, rect_bottom,
		input  ready
	);
	modport sink (
		input  valid, action, page_type, page_column, page_row, clut_column, clut_row,
		       rect_left, rect_top, rect_right, rect_bottom,
		output ready
	);
endinterface

interface tpvt_rsp_if;
	logic valid;
	logic ready;
	logic reload;
	logic bad_type;
	logic palette_dirtied;

	modport source (output valid, reload, bad_type, palette_dirtied, input ready);
	modport sink   (input valid, reload, bad_type, palette_dirtied, output ready);
endinterface

// File: rtl/core/texture_page_valid_tracker_top.sv
// Channel | Direction | Transfer moves
// --------+-----------+-----------------------------------------------------------
// req     | in        | one request: action, page key, palette key, write rectangle
// rsp     | out       | one result per request: reload, bad_type, palette_dirtied
//
// A request passes through two registers: the input register (_s1) and the
// result register. Its result is loaded into the result register as it leaves
// s1; while rsp.ready stays high a new request can be taken every cycle and
// the sustained rate is one per cycle.
// Reset marks every page invalid, the palette dirty and its key zero.
// When the result register is full and not taken, the input register holds
// its request and req.ready drops only once both are full.
module texture_page_valid_tracker_top (
	input  logic              clk,
	input  logic              arst_n,
	tpvt_req_if.sink          req,
	tpvt_rsp_if.source        rsp
);

	// Input register.
	tpvt_pkg::req_t req_s1;
	logic           valid_s1;
	logic           s1_adv;

	// Result register.
	logic out_valid_q;
	logic reload_q;
	logic bad_type_q;
	logic dirtied_q;

	// Tracker state: one valid bit per (type, row, column).
	logic [tpvt_pkg::PAGE_COLUMNS-1:0] valid_q [tpvt_pkg::NUM_TYPES][tpvt_pkg::PAGE_ROWS];
	logic [tpvt_pkg::PAGE_COLUMNS-1:0] valid_d [tpvt_pkg::NUM_TYPES][tpvt_pkg::PAGE_ROWS];
	logic       pal_dirty_q, pal_dirty_d;
	logic [1:0] pal_type_q, pal_type_d;
	logic [5:0] pal_col_q, pal_col_d;
	logic [8:0] pal_row_q, pal_row_d;

	logic reload_d;
	logic bad_type_d;
	logic dirtied_d;

	// The request in s1 moves on when the result register is free or emptying.
	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.action      <= req.action;
			req_s1.page_type   <= req.page_type;
			req_s1.page_column <= req.page_column;
			req_s1.page_row    <= req.page_row;
			req_s1.clut_column <= req.clut_column;
			req_s1.clut_row    <= req.clut_row;
			req_s1.rect_left   <= req.rect_left;
			req_s1.rect_top    <= req.rect_top;
			req_s1.rect_right  <= req.rect_right;
			req_s1.rect_bottom <= req.rect_bottom;
		end
	end

	// Result and next state for the request held in s1.
	always_comb begin
		logic        hit_valid;
		logic        tex_sel;
		logic [10:0] right_c;
		logic [9:0]  bottom_c;
		logic [9:0]  pal_left;
		logic [10:0] pal_right;
		logic [11:0] x_start;
		logic [10:0] y_start;
		logic        row_hit;
		logic        col_hit;

		valid_d     = valid_q;
		pal_dirty_d = pal_dirty_q;
		pal_type_d  = pal_type_q;
		pal_col_d   = pal_col_q;
		pal_row_d   = pal_row_q;
		reload_d    = 1'b0;
		bad_type_d  = 1'b0;
		dirtied_d   = 1'b0;
		hit_valid   = 1'b0;
		tex_sel     = 1'b0;
		x_start     = '0;
		y_start     = '0;
		row_hit     = 1'b0;
		col_hit     = 1'b0;

		// Clamp the exclusive edges to the video memory size.
		right_c  = (req_s1.rect_right > 11'(tpvt_pkg::VRAM_WIDTH)) ?
		           11'(tpvt_pkg::VRAM_WIDTH) : req_s1.rect_right;
		bottom_c = (req_s1.rect_bottom > 10'(tpvt_pkg::VRAM_HEIGHT)) ?
		           10'(tpvt_pkg::VRAM_HEIGHT) : req_s1.rect_bottom;

		// Palette span: 16 halfwords for the 4-bit type, 256 for every other type.
		pal_left  = {pal_col_q, 4'b0000};
		pal_right = {1'b0, pal_left} + ((pal_type_q == tpvt_pkg::TYPE_4BIT) ?
		            11'(tpvt_pkg::CLUT_SMALL) : 11'(tpvt_pkg::CLUT_LARGE));

		for (int t = 0; t < tpvt_pkg::NUM_TYPES; t++) begin
			for (int r = 0; r < tpvt_pkg::PAGE_ROWS; r++) begin
				for (int c = 0; c < tpvt_pkg::PAGE_COLUMNS; c++) begin
					if (32'(req_s1.page_type) == t && 32'(req_s1.page_row) == r &&
					    32'(req_s1.page_column) == c) begin
						hit_valid = valid_q[t][r][c];
					end
				end
			end
		end

		case (req_s1.action)
			tpvt_pkg::ACT_TEX_QUERY: begin
				if (req_s1.page_type == tpvt_pkg::TYPE_24BIT) begin
					bad_type_d = 1'b1;
				end else if (32'(req_s1.page_column) >= tpvt_pkg::PAGE_COLUMNS ||
				             32'(req_s1.page_row) >= tpvt_pkg::PAGE_ROWS) begin
					reload_d = 1'b1;
				end else if (!hit_valid) begin
					reload_d = 1'b1;
					tex_sel  = 1'b1;
				end
				for (int t = 0; t < tpvt_pkg::NUM_TYPES; t++) begin
					for (int r = 0; r < tpvt_pkg::PAGE_ROWS; r++) begin
						for (int c = 0; c < tpvt_pkg::PAGE_COLUMNS; c++) begin
							if (tex_sel && 32'(req_s1.page_type) == t &&
							    32'(req_s1.page_row) == r &&
							    32'(req_s1.page_column) == c) begin
								valid_d[t][r][c] = 1'b1;
							end
						end
					end
				end
			end
			tpvt_pkg::ACT_CLUT_QUERY: begin
				if (pal_dirty_q || pal_type_q != req_s1.page_type ||
				    pal_col_q != req_s1.clut_column || pal_row_q != req_s1.clut_row) begin
					reload_d    = 1'b1;
					pal_type_d  = req_s1.page_type;
					pal_col_d   = req_s1.clut_column;
					pal_row_d   = req_s1.clut_row;
					pal_dirty_d = 1'b0;
				end
			end
			tpvt_pkg::ACT_INVALIDATE: begin
				if (!pal_dirty_q && req_s1.rect_top <= pal_row_q &&
				    {1'b0, pal_row_q} < bottom_c &&
				    {1'b0, req_s1.rect_left} < pal_right &&
				    right_c > {1'b0, pal_left}) begin
					pal_dirty_d = 1'b1;
					dirtied_d   = 1'b1;
				end
				// Every page is compared against the rectangle in parallel.
				for (int r = 0; r < tpvt_pkg::PAGE_ROWS; r++) begin
					y_start = 11'(r * tpvt_pkg::ROW_LINES);
					row_hit = (y_start < {1'b0, bottom_c}) &&
					          ({2'b00, req_s1.rect_top} <
					           y_start + 11'(tpvt_pkg::ROW_LINES));
					for (int c = 0; c < tpvt_pkg::PAGE_COLUMNS; c++) begin
						x_start = 12'(c * tpvt_pkg::COL_HALFWORDS);
						col_hit = x_start < {1'b0, right_c};
						if (row_hit && col_hit) begin
							if ({2'b00, req_s1.rect_left} <
							    x_start + 12'(tpvt_pkg::SPAN16_HALFWORDS)) begin
								valid_d[tpvt_pkg::TYPE_16BIT][r][c] = 1'b0;
							end
							if ({2'b00, req_s1.rect_left} <
							    x_start + 12'(tpvt_pkg::SPAN8_HALFWORDS)) begin
								valid_d[tpvt_pkg::TYPE_8BIT][r][c] = 1'b0;
							end
							if ({2'b00, req_s1.rect_left} <
							    x_start + 12'(tpvt_pkg::COL_HALFWORDS)) begin
								valid_d[tpvt_pkg::TYPE_4BIT][r][c] = 1'b0;
							end
						end
					end
				end
			end
			default: begin
				// The unused action leaves all state alone and reports zeros.
			end
		endcase
	end

	// State and result register update once per request leaving s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < tpvt_pkg::NUM_TYPES; t++) begin
				for (int r = 0; r < tpvt_pkg::PAGE_ROWS; r++) begin
					valid_q[t][r] <= '0;
				end
			end
			pal_dirty_q <= 1'b1;
			pal_type_q  <= '0;
			pal_col_q   <= '0;
			pal_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_q     <= valid_d;
				pal_dirty_q <= pal_dirty_d;
				pal_type_q  <= pal_type_d;
				pal_col_q   <= pal_col_d;
				pal_row_q   <= pal_row_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			reload_q   <= reload_d;
			bad_type_q <= bad_type_d;
			dirtied_q  <= dirtied_d;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.reload          = reload_q;
	assign rsp.bad_type        = bad_type_q;
	assign rsp.palette_dirtied = dirtied_q;

endmodule

// File: tb/tb_texture_page_valid_tracker_top.sv
module tb_texture_page_valid_tracker_top;

	// The package names three actions; the fourth encoding is unused but legal.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// How long the receiver holds off in the back-pressure test. This is long
	// enough that both internal registers fill and the request side stalls.
	localparam int HOLD_OFF_CYCLES = 60;

	// Results come out through the input and result registers, so a tail of
	// TAIL_CYCLES at the end is enough to catch a stray result.
	localparam int TAIL_CYCLES = 8;

	// One expected result, with the same fields as the result channel.
	typedef struct packed {
		logic reload;
		logic bad_type;
		logic palette_dirtied;
	} tracker_result_t;

	logic clk;
	logic arst_n;

	tpvt_req_if req_ch ();
	tpvt_rsp_if rsp_ch ();

	texture_page_valid_tracker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the tracker state. It is updated in transfer order, at
	// the moment each request is accepted, so it always matches what the
	// block must hold after the same requests.
	logic [tpvt_pkg::PAGE_COLUMNS-1:0] page_valid [tpvt_pkg::NUM_TYPES*tpvt_pkg::PAGE_ROWS];
	logic                              clut_dirty;
	logic [1:0]                        clut_type;
	logic [5:0]                        clut_col;
	logic [8:0]                        clut_line;

	// Results that the block still owes, oldest first.
	tracker_result_t expected_results [$];
	tracker_result_t oldest;
	int              errors;

	// Idle rates in percent for the two sides.
	int send_idle_pct;
	int recv_idle_pct;

	// The test raises hold_start; the receiver process turns it into a
	// counted stretch with ready low.
	logic hold_start;
	int   hold_left;

	// A small pool of palette keys. Reusing them is what makes palette hits
	// and palette-overlapping writes common in the random traffic.
	logic [1:0] key_type [4];
	logic [5:0] key_col  [4];
	logic [8:0] key_row  [4];

	// ------------------------------------------------------------------
	// Clock.
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor.
	// ------------------------------------------------------------------
	function automatic void clear_tracker();
		int k;
		for (k = 0; k < tpvt_pkg::NUM_TYPES*tpvt_pkg::PAGE_ROWS; k++) begin
			page_valid[k] = '0;
		end
		clut_dirty = 1'b1;
		clut_type  = tpvt_pkg::TYPE_4BIT;
		clut_col   = '0;
		clut_line  = '0;
	endfunction

	// Apply one accepted request to the shadow state and return the result the
	// block must produce for it.
	function automatic tracker_result_t apply_request(tpvt_pkg::req_t r);
		tracker_result_t res;
		int right_edge;
		int bottom_edge;
		int pal_left;
		int pal_right;
		int idx;
		int i;
		int j;
		int x;

		res = '0;
		right_edge  = (r.rect_right > tpvt_pkg::VRAM_WIDTH) ?
			tpvt_pkg::VRAM_WIDTH : int'(r.rect_right);
		bottom_edge = (r.rect_bottom > tpvt_pkg::VRAM_HEIGHT) ?
			tpvt_pkg::VRAM_HEIGHT : int'(r.rect_bottom);

		case (r.action)
			tpvt_pkg::ACT_TEX_QUERY: begin
				if (r.page_type == tpvt_pkg::TYPE_24BIT) begin
					// Bad type: flagged, no reload and nothing marked.
					res.bad_type = 1'b1;
				end else if (int'(r.page_column) >= tpvt_pkg::PAGE_COLUMNS ||
						int'(r.page_row) >= tpvt_pkg::PAGE_ROWS) begin
					res.reload = 1'b1;
				end else begin
					idx = int'(r.page_type) * tpvt_pkg::PAGE_ROWS + int'(r.page_row);
					if (!page_valid[idx][r.page_column]) begin
						res.reload = 1'b1;
						page_valid[idx][r.page_column] = 1'b1;
					end
				end
			end
			tpvt_pkg::ACT_CLUT_QUERY: begin
				if (clut_dirty || clut_type != r.page_type || clut_col != r.clut_column ||
						clut_line != r.clut_row) begin
					res.reload = 1'b1;
					clut_type  = r.page_type;
					clut_col   = r.clut_column;
					clut_line  = r.clut_row;
					clut_dirty = 1'b0;
				end
			end
			tpvt_pkg::ACT_INVALIDATE: begin
				// The palette is 16 halfwords wide for 4-bit textures and 256 for
				// every other type, the bad type included.
				if (!clut_dirty && int'(r.rect_top) <= int'(clut_line) &&
						int'(clut_line) < bottom_edge) begin
					pal_left  = int'(clut_col) << tpvt_pkg::CLUT_UNIT_SHIFT;
					pal_right = pal_left + ((clut_type == tpvt_pkg::TYPE_4BIT) ?
						tpvt_pkg::CLUT_SMALL : tpvt_pkg::CLUT_LARGE);
					if (int'(r.rect_left) < pal_right && right_edge > pal_left) begin
						clut_dirty          = 1'b1;
						res.palette_dirtied = 1'b1;
					end
				end
				// A page of a wider type reaches further right, so a write that
				// starts to its right can still overlap it.
				for (j = 0; j < tpvt_pkg::PAGE_ROWS &&
						j*tpvt_pkg::ROW_LINES < bottom_edge; j++) begin
					if (int'(r.rect_top) < j*tpvt_pkg::ROW_LINES + tpvt_pkg::ROW_LINES) begin
						for (i = 0; i < tpvt_pkg::PAGE_COLUMNS &&
								i*tpvt_pkg::COL_HALFWORDS < right_edge; i++) begin
							x = i * tpvt_pkg::COL_HALFWORDS;
							if (int'(r.rect_left) < x + tpvt_pkg::SPAN16_HALFWORDS)
								page_valid[int'(tpvt_pkg::TYPE_16BIT)*tpvt_pkg::PAGE_ROWS
									+ j][i] = 1'b0;
							if (int'(r.rect_left) < x + tpvt_pkg::SPAN8_HALFWORDS)
								page_valid[int'(tpvt_pkg::TYPE_8BIT)*tpvt_pkg::PAGE_ROWS
									+ j][i] = 1'b0;
							if (int'(r.rect_left) < x + tpvt_pkg::COL_HALFWORDS)
								page_valid[int'(tpvt_pkg::TYPE_4BIT)*tpvt_pkg::PAGE_ROWS
									+ j][i] = 1'b0;
						end
					end
				end
			end
			default: begin
				// The unused action changes nothing and returns all zeros.
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request builders. Every field that a request does not use is random,
	// so all payload bits toggle even in the directed part.
	// ------------------------------------------------------------------
	function automatic tpvt_pkg::req_t tex_req(logic [1:0] ptype, logic [3:0] col, logic row);
		tpvt_pkg::req_t r;
		r = {$urandom, $urandom};
		r.action      = tpvt_pkg::ACT_TEX_QUERY;
		r.page_type   = ptype;
		r.page_column = col;
		r.page_row    = row;
		return r;
	endfunction

	function automatic tpvt_pkg::req_t clut_req(logic [1:0] ptype, logic [5:0] col,
			logic [8:0] row);
		tpvt_pkg::req_t r;
		r = {$urandom, $urandom};
		r.action      = tpvt_pkg::ACT_CLUT_QUERY;
		r.page_type   = ptype;
		r.clut_column = col;
		r.clut_row    = row;
		return r;
	endfunction

	function automatic tpvt_pkg::req_t rect_req(int left, int top, int right, int bottom);
		tpvt_pkg::req_t r;
		r = {$urandom, $urandom};
		r.action      = tpvt_pkg::ACT_INVALIDATE;
		r.rect_left   = 10'(left);
		r.rect_top    = 9'(top);
		r.rect_right  = 11'(right);
		r.rect_bottom = 10'(bottom);
		return r;
	endfunction

	// Random request with a realistic mix: mostly texture and palette queries
	// and writes that touch pages or the palette, plus raw noise.
	function automatic tpvt_pkg::req_t random_req();
		tpvt_pkg::req_t r;
		int             sel;
		int             k;
		int             v;

		r   = {$urandom, $urandom};
		sel = $urandom_range(99);
		k   = $urandom_range(3);
		if (sel < 38) begin
			r.action = tpvt_pkg::ACT_TEX_QUERY;
			// Keep the bad type present but not dominant.
			if (r.page_type == tpvt_pkg::TYPE_24BIT && $urandom_range(2) != 0)
				r.page_type = 2'($urandom_range(2));
		end else if (sel < 62) begin
			r.action = tpvt_pkg::ACT_CLUT_QUERY;
			if ($urandom_range(3) != 0) begin
				r.page_type   = key_type[k];
				r.clut_column = key_col[k];
				r.clut_row    = key_row[k];
			end
		end else if (sel < 96) begin
			r.action = tpvt_pkg::ACT_INVALIDATE;
			case ($urandom_range(3))
				0: begin
					// Raw fields: right and bottom often beyond the clamp.
				end
				1: begin
					// Small rectangle somewhere in video memory.
					v = $urandom_range(1023);
					r.rect_left  = 10'(v);
					r.rect_right = 11'(v + int'($urandom_range(96)));
					v = $urandom_range(511);
					r.rect_top    = 9'(v);
					r.rect_bottom = 10'(v + int'($urandom_range(300)));
				end
				2: begin
					// Narrow write near one of the pooled palette positions.
					v = int'(key_col[k]) * 16 + int'($urandom_range(300)) - 40;
					if (v < 0)
						v = 0;
					if (v > 1023)
						v = 1023;
					r.rect_left  = 10'(v);
					r.rect_right = 11'(v + int'($urandom_range(1, 48)));
					v = int'(key_row[k]) - int'($urandom_range(2));
					if (v < 0)
						v = 0;
					r.rect_top    = 9'(v);
					r.rect_bottom = 10'(v + int'($urandom_range(4)));
				end
				default: begin
					// Empty or inverted rectangle.
					r.rect_right  = 11'($urandom_range(int'(r.rect_left)));
					r.rect_bottom = 10'($urandom_range(int'(r.rect_top)));
				end
			endcase
		end else begin
			r.action = ACT_UNUSED;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Called at a falling edge; returns at a falling edge
	// with valid still high, so back-to-back requests keep valid up.
	// ------------------------------------------------------------------
	task automatic send_request(tpvt_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= r.action;
		req_ch.page_type   <= r.page_type;
		req_ch.page_column <= r.page_column;
		req_ch.page_row    <= r.page_row;
		req_ch.clut_column <= r.clut_column;
		req_ch.clut_row    <= r.clut_row;
		req_ch.rect_left   <= r.rect_left;
		req_ch.rect_top    <= r.rect_top;
		req_ch.rect_right  <= r.rect_right;
		req_ch.rect_bottom <= r.rect_bottom;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		// The transfer happens at this edge: predict it now, in order.
		expected_results.push_back(apply_request(r));
		@(negedge clk);
	endtask

	// Drop valid; used before pauses and at the end.
	task automatic stop_requests();
		req_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: ready changes at the falling edge. A requested hold-off
	// is counted here so the stall length does not depend on the sender.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left  = HOLD_OFF_CYCLES - 1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result reload=%0b bad_type=%0b palette_dirtied=%0b",
					$time, rsp_ch.reload, rsp_ch.bad_type, rsp_ch.palette_dirtied);
			end else begin
				oldest = expected_results.pop_front();
				if (rsp_ch.reload !== oldest.reload) begin
					errors++;
					$display("%0t: reload expected %0b actual %0b",
						$time, oldest.reload, rsp_ch.reload);
				end
				if (rsp_ch.bad_type !== oldest.bad_type) begin
					errors++;
					$display("%0t: bad_type expected %0b actual %0b",
						$time, oldest.bad_type, rsp_ch.bad_type);
				end
				if (rsp_ch.palette_dirtied !== oldest.palette_dirtied) begin
					errors++;
					$display("%0t: palette_dirtied expected %0b actual %0b",
						$time, oldest.palette_dirtied, rsp_ch.palette_dirtied);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Hand-picked requests: edges of every field, every action, hits and
	// misses, the bad type, clamping and degenerate rectangles.
	task automatic test_directed();
		send_request(tex_req(tpvt_pkg::TYPE_4BIT, 4'd0, 1'b0));      // cold miss
		send_request(tex_req(tpvt_pkg::TYPE_4BIT, 4'd0, 1'b0));      // now a hit
		send_request(tex_req(tpvt_pkg::TYPE_24BIT, 4'd0, 1'b0));     // bad type
		send_request(tex_req(tpvt_pkg::TYPE_16BIT, 4'd15, 1'b1));
		send_request(tex_req(tpvt_pkg::TYPE_8BIT, 4'd15, 1'b1));
		send_request(tex_req(tpvt_pkg::TYPE_16BIT, 4'd15, 1'b1));
		send_request(clut_req(tpvt_pkg::TYPE_4BIT, 6'd0, 9'd0));     // dirty after reset
		send_request(clut_req(tpvt_pkg::TYPE_4BIT, 6'd0, 9'd0));     // same key, hit
		send_request(clut_req(tpvt_pkg::TYPE_24BIT, 6'd63, 9'd511)); // bad type kept as key
		send_request(clut_req(tpvt_pkg::TYPE_24BIT, 6'd63, 9'd511));
		// Right and bottom beyond the edges of video memory are clamped.
		send_request(rect_req(1008, 511, 2047, 1023));
		send_request(rect_req(500, 100, 500, 300));         // empty
		send_request(rect_req(900, 400, 100, 50));          // inverted
		send_request(rect_req(1023, 0, 1023, 512));         // zero width at the edge
		send_request({$urandom, $urandom} | {ACT_UNUSED, 62'd0});
		send_request(clut_req(tpvt_pkg::TYPE_8BIT, 6'd2, 9'd100));
		// A write that ends exactly where the palette starts leaves it alone;
		// one touching its last halfword marks it dirty.
		send_request(rect_req(0, 100, 32, 101));
		send_request(rect_req(287, 100, 288, 101));
		send_request(rect_req(287, 100, 288, 101));         // already dirty
		send_request(rect_req(0, 0, 1024, 512));            // everything
		send_request(tex_req(tpvt_pkg::TYPE_4BIT, 4'd0, 1'b0));
		send_request(tex_req(tpvt_pkg::TYPE_16BIT, 4'd15, 1'b1));
		// A 16-bit page reaches 256 halfwords right of its start.
		send_request(rect_req(1023, 511, 1024, 512));
		send_request(tex_req(tpvt_pkg::TYPE_16BIT, 4'd15, 1'b1));
		send_request(tex_req(tpvt_pkg::TYPE_16BIT, 4'd15, 1'b1));
	endtask

	task automatic test_random_traffic(int count);
		int n;
		for (n = 0; n < count; n++) begin
			send_request(random_req());
		end
	endtask

	// The receiver stops for a long stretch while requests keep coming, so
	// both internal registers fill and the block must stall its input.
	task automatic test_receiver_hold_off();
		int n;
		send_idle_pct = 0;
		// Take valid down first so the last request is not offered again.
		stop_requests();
		@(posedge clk);
		hold_start = 1'b1;
		@(negedge clk);
		for (n = 0; n < 30; n++) begin
			send_request(random_req());
		end
	endtask

	// The sender stops until the block has returned every result, then
	// resumes; the shadow state must still line up afterwards.
	task automatic test_pause_until_drained();
		int n;
		for (n = 0; n < 12; n++) begin
			send_request(random_req());
		end
		stop_requests();
		wait_all_results();
		for (n = 0; n < 12; n++) begin
			send_request(random_req());
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int k;

		errors        = 0;
		send_idle_pct = 14;
		recv_idle_pct = 81;
		hold_start    = 1'b0;
		hold_left     = 0;
		clear_tracker();
		for (k = 0; k < 4; k++) begin
			key_type[k] = 2'($urandom);
			key_col[k]  = 6'($urandom);
			key_row[k]  = 9'($urandom);
		end

		// Every input is known from time zero.
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = tpvt_pkg::ACT_TEX_QUERY;
		req_ch.page_type   = tpvt_pkg::TYPE_4BIT;
		req_ch.page_column = '0;
		req_ch.page_row    = 1'b0;
		req_ch.clut_column = '0;
		req_ch.clut_row    = '0;
		req_ch.rect_left   = '0;
		req_ch.rect_top    = '0;
		req_ch.rect_right  = '0;
		req_ch.rect_bottom = '0;
		rsp_ch.ready       = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Phase one: the sender rarely idles, the receiver mostly stalls.
		test_directed();
		test_random_traffic(480);
		test_pause_until_drained();

		// Phase two: the other way round.
		send_idle_pct = 81;
		recv_idle_pct = 14;
		test_random_traffic(480);

		// Phase three: full rate on both sides, then the long hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(500);
		test_receiver_hold_off();

		stop_requests();
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Safety net well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
